// ===== sv/rfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types, codes and constants of the radio receive frame dispatcher.
// ----------------------------------------------------------------------------
package rfd_pkg;

	localparam int RC_CHANNELS_DEF = 8;
	localparam int FIFO_DEPTH_DEF  = 128;
	localparam int JOBQ_DEPTH      = 2;

	localparam int COUNT_W = 7;
	localparam int IDX_W   = 4;
	localparam int WORD_W  = 16;
	localparam int HDR_LEN = 7;

	// input commands
	localparam logic CMD_FRAME_BYTE = 1'b0;
	localparam logic CMD_POP        = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_POP     = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_VERDICT = 2'd2;
	localparam logic [1:0] KIND_CHANNEL = 2'd3;

	// frame verdicts
	localparam logic [2:0] ST_BAD_HEADER    = 3'd0;
	localparam logic [2:0] ST_NOT_ADDRESSED = 3'd1;
	localparam logic [2:0] ST_FLIGHT_OK     = 3'd2;
	localparam logic [2:0] ST_CSUM_FAIL     = 3'd3;
	localparam logic [2:0] ST_SERIAL        = 3'd4;
	localparam logic [2:0] ST_DISC_REQ      = 3'd5;
	localparam logic [2:0] ST_DISC_REPLY    = 3'd6;
	localparam logic [2:0] ST_UNKNOWN       = 3'd7;

	// frame types
	localparam logic [7:0] TYPE_FLIGHT     = 8'h00;
	localparam logic [7:0] TYPE_SERIAL     = 8'h01;
	localparam logic [7:0] TYPE_DISC_REQ   = 8'h02;
	localparam logic [7:0] TYPE_DISC_REPLY = 8'h03;

	localparam logic [7:0] BROADCAST_ADDR = 8'hFF;

	// register indexes
	localparam logic REG_DEVICE_ADDRESS   = 1'b0;
	localparam logic REG_COORDINATOR_MODE = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] frame_byte;
		logic       frame_end;
	} req_t;

	typedef struct packed {
		logic [1:0]         result_kind;
		logic [7:0]         read_byte;
		logic [COUNT_W-1:0] fifo_count;
		logic [2:0]         frame_status;
		logic [IDX_W-1:0]   channel_index;
		logic [WORD_W-1:0]  channel_value;
		logic               discovered;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic [7:0] device_address;
		logic       coordinator_mode;
	} cfg_t;

	// one queued job: the results that one accepted item causes
	typedef struct packed {
		logic               is_pop;
		logic               pop_empty;
		logic               commit;
		logic               verdict;
		logic [2:0]         status;
		logic [COUNT_W-1:0] fifo_count;
		logic               discovered;
	} job_t;

	function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
		logic [7:0] val;
		case (pos)
			3'd0:    val = 8'h01;
			3'd1:    val = 8'h80;
			3'd2:    val = 8'h00;
			3'd3:    val = 8'h11;
			3'd4:    val = 8'h22;
			3'd5:    val = 8'h33;
			3'd6:    val = 8'h44;
			default: val = 8'h00;
		endcase
		return val;
	endfunction

endpackage

// ===== sv/rfd_front.sv =====
// ----------------------------------------------------------------------------
// rfd_front
// Accepts items, parses frames, owns the receive fifo and emits one job per
// item that causes results.
// ----------------------------------------------------------------------------
module rfd_front #(
	parameter int RC_CHANNELS = rfd_pkg::RC_CHANNELS_DEF,
	parameter int FIFO_DEPTH  = rfd_pkg::FIFO_DEPTH_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  rfd_pkg::cfg_t                            cfg,
	input  logic                                     req_valid,
	input  rfd_pkg::req_t                            req,
	output logic                                     req_stall,
	input  logic                                     q_full,
	output logic                                     job_valid,
	output rfd_pkg::job_t                            job,
	output logic [RC_CHANNELS-1:0][rfd_pkg::WORD_W-1:0] job_words,
	output logic [7:0]                               job_byte
);

	localparam int PW  = $clog2(FIFO_DEPTH);
	localparam int CIW = (RC_CHANNELS > 1) ? $clog2(RC_CHANNELS) : 1;
	localparam logic [7:0] CSUM_POS = 8'(9 + 2 * RC_CHANNELS);

	logic [7:0]    pos_q, sum_q, ft_q, pl_q;
	logic          hg_q, ad_q, sm_q, disc_q;
	logic [PW-1:0] head_q, tail_q;
	logic [RC_CHANNELS-1:0][rfd_pkg::WORD_W-1:0] pend_q;
	logic [7:0]    mem [FIFO_DEPTH];

	logic [7:0]    pos_d, sum_d, ft_d, pl_d;
	logic          hg_d, ad_d, sm_d, disc_d;
	logic [PW-1:0] head_d, tail_d, head_nxt, tail_nxt;
	logic          mem_we, rd_en, pend_we, pend_hi, commit, pop_empty, qb, needs;
	logic [2:0]    st;
	logic [7:0]    b, off;
	logic [CIW-1:0] k;
	logic [PW:0]   lvl;
	logic          acc;

	logic          valid_s1;
	rfd_pkg::job_t job_s1;
	logic [RC_CHANNELS-1:0][rfd_pkg::WORD_W-1:0] words_s1;
	logic [7:0]    rbyte_s1;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] x);
		return (x == PW'(FIFO_DEPTH - 1)) ? '0 : x + 1'b1;
	endfunction

	assign req_stall = valid_s1 && q_full;
	assign acc       = req_valid && !req_stall;
	assign b         = req.frame_byte;
	assign off       = pos_q - 8'd9;
	assign k         = off[CIW:1];
	assign head_nxt  = ptr_inc(head_q);
	assign tail_nxt  = ptr_inc(tail_q);

	always_comb begin
		pos_d     = pos_q;
		sum_d     = sum_q;
		hg_d      = hg_q;
		ad_d      = ad_q;
		ft_d      = ft_q;
		pl_d      = pl_q;
		sm_d      = sm_q;
		disc_d    = disc_q;
		head_d    = head_q;
		tail_d    = tail_q;
		mem_we    = 1'b0;
		rd_en     = 1'b0;
		pend_we   = 1'b0;
		pend_hi   = 1'b0;
		commit    = 1'b0;
		pop_empty = 1'b0;
		qb        = 1'b0;
		st        = rfd_pkg::ST_BAD_HEADER;
		if (req.command == rfd_pkg::CMD_POP) begin
			if (head_q == tail_q) begin
				pop_empty = 1'b1;
			end else begin
				rd_en  = 1'b1;
				tail_d = tail_nxt;
			end
		end else begin
			if (pos_q < 8'(rfd_pkg::HDR_LEN)) begin
				if (pos_q == 8'd0) begin
					hg_d  = 1'b1;
					sum_d = '0;
					ad_d  = 1'b0;
					ft_d  = '0;
					pl_d  = '0;
					sm_d  = 1'b0;
				end
				hg_d = hg_d && (b == rfd_pkg::hdr_byte(pos_q[2:0]));
			end else if (pos_q == 8'd7) begin
				ad_d = hg_q && (cfg.coordinator_mode || b == rfd_pkg::BROADCAST_ADDR ||
					b == cfg.device_address);
			end else if (hg_q && ad_q) begin
				if (pos_q == 8'd8) begin
					ft_d = b;
				end else if (ft_q == rfd_pkg::TYPE_FLIGHT) begin
					if (pos_q < CSUM_POS) begin
						pend_we = 1'b1;
						pend_hi = off[0];
						sum_d   = sum_q + b;
					end else if (pos_q == CSUM_POS) begin
						sm_d   = (b == sum_q);
						commit = sm_d;
					end else if (pos_q == CSUM_POS + 8'd1) begin
						if (sm_q) pl_d = b;
					end else if (sm_q) begin
						qb = 1'b1;
					end
				end else if (ft_q == rfd_pkg::TYPE_SERIAL) begin
					if (pos_q == 8'd9) pl_d = b;
					else qb = 1'b1;
				end
			end
			// a byte that does not fit drops the rest of the frame's serial bytes
			if (qb && pl_q != 8'd0) begin
				if (head_nxt == tail_q) begin
					pl_d = '0;
				end else begin
					mem_we = 1'b1;
					head_d = head_nxt;
					pl_d   = pl_q - 8'd1;
				end
			end
			if (pos_q < 8'(rfd_pkg::HDR_LEN) || !hg_d) st = rfd_pkg::ST_BAD_HEADER;
			else if (!ad_d) st = rfd_pkg::ST_NOT_ADDRESSED;
			else if (pos_q < 8'd8) st = rfd_pkg::ST_UNKNOWN;
			else begin
				case (ft_d)
					rfd_pkg::TYPE_FLIGHT:     st = sm_d ? rfd_pkg::ST_FLIGHT_OK
						: rfd_pkg::ST_CSUM_FAIL;
					rfd_pkg::TYPE_SERIAL:     st = rfd_pkg::ST_SERIAL;
					rfd_pkg::TYPE_DISC_REQ:   st = rfd_pkg::ST_DISC_REQ;
					rfd_pkg::TYPE_DISC_REPLY: st = rfd_pkg::ST_DISC_REPLY;
					default:                  st = rfd_pkg::ST_UNKNOWN;
				endcase
			end
			if (req.frame_end) begin
				pos_d = '0;
				if (st == rfd_pkg::ST_DISC_REPLY) disc_d = 1'b1;
			end else begin
				pos_d = (pos_q == 8'hFF) ? 8'hFF : pos_q + 8'd1;
			end
		end
	end

	assign lvl   = {1'b0, head_d} + ((head_d < tail_d) ? (PW+1)'(FIFO_DEPTH) : '0)
		- {1'b0, tail_d};
	assign needs = (req.command == rfd_pkg::CMD_POP) || commit || req.frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			sum_q  <= '0;
			hg_q   <= 1'b1;
			ad_q   <= 1'b0;
			ft_q   <= '0;
			pl_q   <= '0;
			sm_q   <= 1'b0;
			disc_q <= 1'b0;
			head_q <= '0;
			tail_q <= '0;
		end else if (acc) begin
			pos_q  <= pos_d;
			sum_q  <= sum_d;
			hg_q   <= hg_d;
			ad_q   <= ad_d;
			ft_q   <= ft_d;
			pl_q   <= pl_d;
			sm_q   <= sm_d;
			disc_q <= disc_d;
			head_q <= head_d;
			tail_q <= tail_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < RC_CHANNELS; i++) begin
			if (acc && pend_we && k == CIW'(i)) begin
				pend_q[i] <= pend_hi ? (pend_q[i] | {b, 8'h00}) : {8'h00, b};
			end
		end
	end

	// receive fifo storage, read data registered into the job stage
	always_ff @(posedge clk) begin
		if (acc && mem_we) mem[head_q] <= b;
		if (acc && rd_en) rbyte_s1 <= mem[tail_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= acc && needs;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			job_s1.is_pop     <= (req.command == rfd_pkg::CMD_POP);
			job_s1.pop_empty  <= pop_empty;
			job_s1.commit     <= commit && (req.command == rfd_pkg::CMD_FRAME_BYTE);
			job_s1.verdict    <= req.frame_end && (req.command == rfd_pkg::CMD_FRAME_BYTE);
			job_s1.status     <= st;
			job_s1.fifo_count <= rfd_pkg::COUNT_W'(lvl);
			job_s1.discovered <= disc_d;
			words_s1          <= pend_q;
		end
	end

	assign job_valid = valid_s1;
	assign job       = job_s1;
	assign job_words = words_s1;
	assign job_byte  = rbyte_s1;

endmodule

// ===== sv/rfd_jobq.sv =====
// ----------------------------------------------------------------------------
// rfd_jobq
// Small first-in first-out queue of jobs between front and back.
// ----------------------------------------------------------------------------
module rfd_jobq #(
	parameter int WIDTH = 8,
	parameter int DEPTH = rfd_pkg::JOBQ_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int QW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] ent_q [DEPTH];
	logic [QW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == QW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop) rd_q <= (rd_q == QW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) ent_q[wr_q] <= din;
	end

endmodule

// ===== sv/rfd_back.sv =====
// ----------------------------------------------------------------------------
// rfd_back
// Expands each queued job into its result transfers, one per cycle while rsp
// is not stalled, through an output register.
// ----------------------------------------------------------------------------
module rfd_back #(
	parameter int RC_CHANNELS = rfd_pkg::RC_CHANNELS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     q_empty,
	input  rfd_pkg::job_t                            job,
	input  logic [RC_CHANNELS-1:0][rfd_pkg::WORD_W-1:0] job_words,
	input  logic [7:0]                               job_byte,
	output logic                                     q_pop,
	output logic                                     rsp_valid,
	input  logic                                     rsp_stall,
	output rfd_pkg::rsp_t                            rsp
);

	localparam int IW = $clog2(RC_CHANNELS + 1);

	logic [IW-1:0]              idx_q;
	logic                       rsp_valid_q;
	rfd_pkg::rsp_t              rsp_q;
	rfd_pkg::rsp_t              cur;
	logic                       in_ch, load;
	logic [rfd_pkg::WORD_W-1:0] cur_word;

	assign in_ch = job.commit && (idx_q < IW'(RC_CHANNELS));
	assign load  = !q_empty && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		cur_word = '0;
		for (int i = 0; i < RC_CHANNELS; i++) begin
			if (idx_q == IW'(i)) cur_word = job_words[i];
		end
	end

	always_comb begin
		cur               = '0;
		cur.fifo_count    = job.fifo_count;
		cur.discovered    = job.discovered;
		if (in_ch) begin
			cur.result_kind   = rfd_pkg::KIND_CHANNEL;
			cur.channel_index = rfd_pkg::IDX_W'(idx_q);
			cur.channel_value = cur_word;
			cur.last          = !job.verdict && (idx_q == IW'(RC_CHANNELS - 1));
		end else if (job.is_pop) begin
			cur.result_kind = job.pop_empty ? rfd_pkg::KIND_EMPTY : rfd_pkg::KIND_POP;
			cur.read_byte   = job.pop_empty ? 8'h00 : job_byte;
			cur.last        = 1'b1;
		end else begin
			cur.result_kind  = rfd_pkg::KIND_VERDICT;
			cur.frame_status = job.status;
			cur.last         = 1'b1;
		end
	end

	assign q_pop = load && cur.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (!rsp_valid_q || !rsp_stall) rsp_valid_q <= !q_empty;
			if (load) idx_q <= cur.last ? '0 : idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) rsp_q <= cur;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== sv/radio_rx_frame_dispatcher_core.sv =====
// ----------------------------------------------------------------------------
// radio_rx_frame_dispatcher_core
// Receive frame dispatcher: header check, address filter, flight channel
// commit, serial byte fifo and discovery handling.
// ----------------------------------------------------------------------------
// usage:
// req carries one item per transfer: a received frame byte (frame_end on the
// last byte of a frame) or a pop of one byte from the receive fifo.
// rsp carries the results in order; last marks the final result of an item.
// a pop gives one result, a frame byte gives none or a verdict on frame_end,
// and the checksum byte of a good flight frame gives one result per channel.
// the front accepts one item per cycle while req_stall is low; the back sends
// one result per cycle while rsp is not stalled, so a committing flight frame
// gives RC_CHANNELS channel results on rsp. the first result of an item passes
// through the job stage (which also covers the fifo memory read), the job
// queue and the output register; the job stage loads at the edge accepting
// its item. a two-entry job queue lets the front keep taking items that
// cause no results while rsp is stalled; req_stall rises only when the job
// stage holds a job and the queue is full.
// after reset the fifo is empty, the header state is cleared, registers
// read zero and no result is pending. device_address and coordinator_mode
// sit on the apb port at byte addresses 0 and 4.
// ----------------------------------------------------------------------------
module radio_rx_frame_dispatcher_core #(
	parameter int RC_CHANNELS = rfd_pkg::RC_CHANNELS_DEF,
	parameter int FIFO_DEPTH  = rfd_pkg::FIFO_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	input  logic          req_valid,
	output logic          req_stall,
	input  rfd_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rfd_pkg::rsp_t rsp
);

	localparam int WW = RC_CHANNELS * rfd_pkg::WORD_W;
	localparam int QW = $bits(rfd_pkg::job_t) + WW + 8;

	rfd_pkg::cfg_t cfg_q;
	logic          cfg_wr;

	logic          job_valid, q_full, q_empty, q_pop;
	rfd_pkg::job_t job_in, job_out;
	logic [RC_CHANNELS-1:0][rfd_pkg::WORD_W-1:0] words_in, words_out;
	logic [7:0]    byte_in, byte_out;
	logic [QW-1:0] q_din, q_dout;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				rfd_pkg::REG_DEVICE_ADDRESS:   cfg_q.device_address   <= pwdata[7:0];
				rfd_pkg::REG_COORDINATOR_MODE: cfg_q.coordinator_mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			rfd_pkg::REG_DEVICE_ADDRESS:   prdata = {24'h0, cfg_q.device_address};
			rfd_pkg::REG_COORDINATOR_MODE: prdata = {31'h0, cfg_q.coordinator_mode};
			default:                       prdata = '0;
		endcase
	end

	rfd_front #(
		.RC_CHANNELS(RC_CHANNELS),
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.req_valid(req_valid),
		.req      (req),
		.req_stall(req_stall),
		.q_full   (q_full),
		.job_valid(job_valid),
		.job      (job_in),
		.job_words(words_in),
		.job_byte (byte_in)
	);

	assign q_din = {job_in, words_in, byte_in};

	rfd_jobq #(
		.WIDTH(QW),
		.DEPTH(rfd_pkg::JOBQ_DEPTH)
	) u_jobq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (job_valid),
		.din   (q_din),
		.full  (q_full),
		.pop   (q_pop),
		.dout  (q_dout),
		.empty (q_empty)
	);

	assign job_out   = q_dout[QW-1 -: $bits(rfd_pkg::job_t)];
	assign words_out = q_dout[WW+7:8];
	assign byte_out  = q_dout[7:0];

	rfd_back #(
		.RC_CHANNELS(RC_CHANNELS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.job      (job_out),
		.job_words(words_out),
		.job_byte (byte_out),
		.q_pop    (q_pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the radio receive frame dispatcher. Sends frames,
// fifo pops and noise through the req channel with random bursts and gaps,
// while the rsp side stalls on its own pattern. A behavioral model of the
// dispatcher predicts every result, and each rsp transfer is checked field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int N_CHANNELS   = rfd_pkg::RC_CHANNELS_DEF;
	localparam int CSUM_POS     = 9 + 2 * N_CHANNELS;
	localparam int RANDOM_ITEMS = 40;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT  = 4000;
	localparam logic [8*rfd_pkg::HDR_LEN-1:0] HDR_SEQ = 56'h01_80_00_11_22_33_44;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          psel;
	logic          penable;
	logic          pwrite;
	logic [2:0]    paddr;
	logic [31:0]   pwdata;
	logic [31:0]   prdata;
	logic          pready;
	logic          req_valid;
	logic          req_stall;
	rfd_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_stall;
	rfd_pkg::rsp_t rsp;

	radio_rx_frame_dispatcher_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	// dispatcher model state
	logic [7:0]  cfg_addr;
	logic        cfg_coord;
	logic [7:0]  byte_pos;
	logic [7:0]  run_sum;
	logic        hdr_ok;
	logic        addressed;
	logic [7:0]  ftype;
	logic [7:0]  pay_len;
	logic        sum_ok;
	logic [15:0] pend_words [N_CHANNELS];
	logic [15:0] chan_words [N_CHANNELS];
	logic [7:0]  fifo_mem [rfd_pkg::FIFO_DEPTH_DEF];
	logic [6:0]  fifo_head;
	logic [6:0]  fifo_tail;
	logic        disc_flag;

	rfd_pkg::rsp_t due_results[$];
	logic [7:0]    frame_bytes[$];
	int            mismatch_count = 0;
	int            items_sent = 0;
	int            burst_left = 0;
	bit            hold_rsp_req = 1'b0;

	task automatic model_reset();
		cfg_addr  = '0;
		cfg_coord = 1'b0;
		byte_pos  = '0;
		run_sum   = '0;
		hdr_ok    = 1'b1;
		addressed = 1'b0;
		ftype     = '0;
		pay_len   = '0;
		sum_ok    = 1'b0;
		for (int i = 0; i < N_CHANNELS; i++) begin
			pend_words[i] = '0;
			chan_words[i] = '0;
		end
		for (int i = 0; i < rfd_pkg::FIFO_DEPTH_DEF; i++)
			fifo_mem[i] = '0;
		fifo_head = '0;
		fifo_tail = '0;
		disc_flag = 1'b0;
	endtask

	function automatic logic [6:0] fifo_level();
		return 7'(fifo_head - fifo_tail);
	endfunction

	function automatic rfd_pkg::rsp_t make_rsp(input logic [1:0] kind, input logic [7:0] rb,
			input logic [2:0] st, input logic [3:0] idx, input logic [15:0] val);
		rfd_pkg::rsp_t r;
		r.result_kind   = kind;
		r.read_byte     = rb;
		r.fifo_count    = fifo_level();
		r.frame_status  = st;
		r.channel_index = idx;
		r.channel_value = val;
		r.discovered    = disc_flag;
		r.last          = 1'b0;
		return r;
	endfunction

	function automatic string rsp_str(input rfd_pkg::rsp_t r);
		string s;
		s = $sformatf("kind=%0d byte=%02h cnt=%0d st=%0d idx=%0d val=%04h disc=%b last=%b",
			r.result_kind, r.read_byte, r.fifo_count, r.frame_status, r.channel_index,
			r.channel_value, r.discovered, r.last);
		return s;
	endfunction

	// a byte that does not fit drops the rest of the frame's serial bytes
	task automatic queue_serial(input logic [7:0] b);
		logic [6:0] next_head;
		if (pay_len == 0)
			return;
		next_head = fifo_head + 7'd1;
		if (next_head == fifo_tail) begin
			pay_len = '0;
			return;
		end
		fifo_mem[fifo_head] = b;
		fifo_head = next_head;
		pay_len = pay_len - 8'd1;
	endtask

	function automatic logic [2:0] frame_verdict(input logic [7:0] pos);
		if (pos < rfd_pkg::HDR_LEN || !hdr_ok)
			return rfd_pkg::ST_BAD_HEADER;
		if (!addressed)
			return rfd_pkg::ST_NOT_ADDRESSED;
		if (pos == rfd_pkg::HDR_LEN)
			return rfd_pkg::ST_UNKNOWN;
		case (ftype)
			rfd_pkg::TYPE_FLIGHT:     return sum_ok ? rfd_pkg::ST_FLIGHT_OK
				: rfd_pkg::ST_CSUM_FAIL;
			rfd_pkg::TYPE_SERIAL:     return rfd_pkg::ST_SERIAL;
			rfd_pkg::TYPE_DISC_REQ:   return rfd_pkg::ST_DISC_REQ;
			rfd_pkg::TYPE_DISC_REPLY: return rfd_pkg::ST_DISC_REPLY;
			default:                  return rfd_pkg::ST_UNKNOWN;
		endcase
	endfunction

	task automatic predict_dispatch(input rfd_pkg::req_t item);
		rfd_pkg::rsp_t step_rsps[$];
		rfd_pkg::rsp_t r;
		logic [7:0]    b;
		logic [7:0]    pos;
		logic [2:0]    st;
		int            k;
		if (item.command == rfd_pkg::CMD_POP) begin
			if (fifo_head == fifo_tail) begin
				step_rsps.push_back(make_rsp(rfd_pkg::KIND_EMPTY, '0, '0, '0, '0));
			end else begin
				b = fifo_mem[fifo_tail];
				fifo_tail = fifo_tail + 7'd1;
				step_rsps.push_back(make_rsp(rfd_pkg::KIND_POP, b, '0, '0, '0));
			end
		end else begin
			b = item.frame_byte;
			pos = byte_pos;
			if (pos < rfd_pkg::HDR_LEN) begin
				if (pos == 0) begin
					hdr_ok    = 1'b1;
					run_sum   = '0;
					addressed = 1'b0;
					ftype     = '0;
					pay_len   = '0;
					sum_ok    = 1'b0;
				end
				hdr_ok = hdr_ok && (b == HDR_SEQ[(rfd_pkg::HDR_LEN - 1 - pos) * 8 +: 8]);
			end else if (pos == rfd_pkg::HDR_LEN) begin
				addressed = hdr_ok && (cfg_coord || b == rfd_pkg::BROADCAST_ADDR ||
					b == cfg_addr);
			end else if (hdr_ok && addressed) begin
				if (pos == rfd_pkg::HDR_LEN + 1) begin
					ftype = b;
				end else if (ftype == rfd_pkg::TYPE_FLIGHT) begin
					if (pos < CSUM_POS) begin
						k = (pos - 9) >> 1;
						// odd positions carry the low byte of a word
						if (pos[0])
							pend_words[k] = {8'h00, b};
						else
							pend_words[k][15:8] = b;
						run_sum = run_sum + b;
					end else if (pos == CSUM_POS) begin
						sum_ok = (b == run_sum);
						if (sum_ok) begin
							for (int i = 0; i < N_CHANNELS; i++) begin
								chan_words[i] = pend_words[i];
								step_rsps.push_back(make_rsp(rfd_pkg::KIND_CHANNEL, '0, '0,
									4'(i), chan_words[i]));
							end
						end
					end else if (pos == CSUM_POS + 1) begin
						if (sum_ok)
							pay_len = b;
					end else if (sum_ok) begin
						queue_serial(b);
					end
				end else if (ftype == rfd_pkg::TYPE_SERIAL) begin
					if (pos == rfd_pkg::HDR_LEN + 2)
						pay_len = b;
					else
						queue_serial(b);
				end
			end
			if (item.frame_end) begin
				st = frame_verdict(pos);
				if (st == rfd_pkg::ST_DISC_REPLY)
					disc_flag = 1'b1;
				step_rsps.push_back(make_rsp(rfd_pkg::KIND_VERDICT, '0, st, '0, '0));
				byte_pos = '0;
			end else begin
				byte_pos = (pos < 8'd255) ? pos + 8'd1 : 8'd255;
			end
		end
		foreach (step_rsps[i]) begin
			r = step_rsps[i];
			r.last = (i == step_rsps.size() - 1);
			due_results.push_back(r);
		end
	endtask

	// ------------------------------------------------------------------ stimulus

	task automatic send_item(input rfd_pkg::req_t item);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				req_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		predict_dispatch(item);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic fin);
		rfd_pkg::req_t item;
		item.command    = rfd_pkg::CMD_FRAME_BYTE;
		item.frame_byte = b;
		item.frame_end  = fin;
		send_item(item);
	endtask

	// frame_byte and frame_end carry junk on a pop
	task automatic send_pop();
		rfd_pkg::req_t item;
		item.command    = rfd_pkg::CMD_POP;
		item.frame_byte = 8'($urandom);
		item.frame_end  = 1'($urandom);
		send_item(item);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic idx, input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == rfd_pkg::REG_DEVICE_ADDRESS)
			cfg_addr = data[7:0];
		else
			cfg_coord = data[0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_config(input logic [7:0] addr, input logic coord);
		wait_drained();
		apb_write(rfd_pkg::REG_DEVICE_ADDRESS, {24'($urandom), addr});
		apb_write(rfd_pkg::REG_COORDINATOR_MODE, {31'($urandom), coord});
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 5))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic int rand_len();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
	endfunction

	function automatic logic [7:0] pick_dest();
		case ($urandom_range(0, 3))
			0:       return cfg_addr;
			1:       return rfd_pkg::BROADCAST_ADDR;
			2:       return cfg_addr ^ 8'(1 << $urandom_range(0, 7));
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic begin_frame(input logic [7:0] dest, input logic [7:0] type_byte);
		frame_bytes.delete();
		for (int i = 0; i < rfd_pkg::HDR_LEN; i++)
			frame_bytes.push_back(HDR_SEQ[(rfd_pkg::HDR_LEN - 1 - i) * 8 +: 8]);
		frame_bytes.push_back(dest);
		frame_bytes.push_back(type_byte);
	endtask

	task automatic build_flight(input logic [7:0] dest, input bit good_sum,
			input int ser_len, input int ser_count);
		logic [7:0] sum;
		logic [7:0] b;
		begin_frame(dest, rfd_pkg::TYPE_FLIGHT);
		sum = '0;
		repeat (2 * N_CHANNELS) begin
			b = rand_byte();
			sum = sum + b;
			frame_bytes.push_back(b);
		end
		frame_bytes.push_back(good_sum ? sum : sum + 8'($urandom_range(1, 255)));
		frame_bytes.push_back(8'(ser_len));
		repeat (ser_count) frame_bytes.push_back(rand_byte());
	endtask

	task automatic build_serial(input logic [7:0] dest, input int ser_len, input int ser_count);
		begin_frame(dest, rfd_pkg::TYPE_SERIAL);
		frame_bytes.push_back(8'(ser_len));
		repeat (ser_count) frame_bytes.push_back(rand_byte());
	endtask

	// sends the first keep bytes (all when keep is 0), frame_end on the last one,
	// with pops slipped in between bytes
	task automatic send_frame(input int keep, input int pop_pct);
		int n;
		n = (keep > 0 && keep < frame_bytes.size()) ? keep : frame_bytes.size();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < pop_pct)
				send_pop();
			send_byte(frame_bytes[i], i == n - 1);
		end
	endtask

	task automatic random_frame();
		int         pick;
		int         keep;
		int         k;
		logic [7:0] dest;
		dest = pick_dest();
		keep = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 30) : 0;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			build_flight(dest, $urandom_range(0, 6) != 0, rand_len(), $urandom_range(0, 8));
		end else if (pick < 65) begin
			build_serial(dest, rand_len(), $urandom_range(0, 10));
		end else if (pick < 80) begin
			case ($urandom_range(0, 2))
				0:       begin_frame(dest, rfd_pkg::TYPE_DISC_REQ);
				1:       begin_frame(dest, rfd_pkg::TYPE_DISC_REPLY);
				default: begin_frame(dest, 8'($urandom));
			endcase
			repeat ($urandom_range(0, 3)) frame_bytes.push_back(rand_byte());
		end else if (pick < 90) begin
			build_serial(dest, 3, 3);
			k = $urandom_range(0, rfd_pkg::HDR_LEN - 1);
			frame_bytes[k] = frame_bytes[k] ^ 8'(1 << $urandom_range(0, 7));
		end else begin
			frame_bytes.delete();
			repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom));
		end
		send_frame(keep, 8);
	endtask

	// ------------------------------------------------------------------ tests

	task automatic test_directed();
		send_pop();
		begin_frame(rfd_pkg::BROADCAST_ADDR, rfd_pkg::TYPE_SERIAL);
		send_frame(3, 0);                        // header cut short
		begin_frame(rfd_pkg::BROADCAST_ADDR, rfd_pkg::TYPE_DISC_REQ);
		frame_bytes[2] = ~frame_bytes[2];        // corrupt header byte
		send_frame(0, 0);
		begin_frame(8'h37, rfd_pkg::TYPE_DISC_REPLY);   // not our address
		send_frame(0, 0);
		begin_frame(rfd_pkg::BROADCAST_ADDR, rfd_pkg::TYPE_SERIAL);
		send_frame(rfd_pkg::HDR_LEN + 1, 0);     // ends on the address byte
		build_flight(8'h00, 1'b1, 3, 3);         // own address after reset
		send_frame(0, 0);
		build_flight(rfd_pkg::BROADCAST_ADDR, 1'b0, 2, 2);
		send_frame(0, 0);
		build_flight(rfd_pkg::BROADCAST_ADDR, 1'b1, 0, 0);
		send_frame(16, 0);                       // ends before the checksum
		build_flight(rfd_pkg::BROADCAST_ADDR, 1'b1, 0, 0);
		send_frame(CSUM_POS + 1, 0);             // ends on the checksum byte
		build_serial(rfd_pkg::BROADCAST_ADDR, 10, 4);   // length runs past frame end
		send_frame(0, 0);
		begin_frame(rfd_pkg::BROADCAST_ADDR, rfd_pkg::TYPE_DISC_REQ);
		send_frame(0, 0);
		begin_frame(rfd_pkg::BROADCAST_ADDR, rfd_pkg::TYPE_DISC_REPLY);
		send_frame(0, 0);
		begin_frame(rfd_pkg::BROADCAST_ADDR, 8'($urandom_range(4, 255)));
		send_frame(0, 0);
		repeat (9) send_pop();
		wait_drained();
	endtask

	// fills the fifo until a byte is dropped, then leaves it nearly full
	task automatic test_fifo_full();
		build_serial(rfd_pkg::BROADCAST_ADDR, 200, 130);
		send_frame(0, 0);
		repeat (6) send_pop();
		wait_drained();
	endtask

	task automatic test_config_sweep();
		logic [7:0] addrs [2];
		logic       coords [2];
		logic [7:0] dests [2];
		addrs  = '{8'hA5, 8'h5A};
		coords = '{1'b1, 1'b0};
		for (int s = 0; s < 2; s++) begin
			set_config(addrs[s], coords[s]);
			dests = '{addrs[s], addrs[s] ^ 8'h01};
			for (int d = 0; d < 2; d++) begin
				begin_frame(dests[d], rfd_pkg::TYPE_DISC_REQ);
				send_frame(0, 0);
			end
		end
	endtask

	task automatic test_backpressure();
		wait_drained();
		hold_rsp_req = 1'b1;
		wait (!hold_rsp_req);
		build_flight(rfd_pkg::BROADCAST_ADDR, 1'b1, 2, 2);
		send_frame(0, 30);
		repeat (8) send_pop();
		wait_drained();
		repeat (4) send_pop();
	endtask

	task automatic test_random_traffic();
		int stop_at;
		for (int phase = 0; phase < 2; phase++) begin
			set_config(8'($urandom), phase[0]);
			stop_at = items_sent + RANDOM_ITEMS / 2;
			while (items_sent < stop_at) begin
				if ($urandom_range(0, 4) == 0 || fifo_level() > 90)
					repeat ($urandom_range(1, 10)) send_pop();
				random_frame();
			end
		end
	endtask

	// ------------------------------------------------------------------ processes

	initial begin : rsp_receiver
		int mode;
		int span;
		int tick;
		rsp_stall = 1'b0;
		tick = 0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(16, 120);
			repeat (span) begin
				@(negedge clk);
				tick++;
				if (hold_rsp_req) begin
					rsp_stall <= 1'b1;
					hold_rsp_req = 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
				end else begin
					case (mode)
						0:       rsp_stall <= 1'b0;
						1:       rsp_stall <= ($urandom_range(0, 3) == 0);
						2:       rsp_stall <= ($urandom_range(0, 9) < 7);
						default: rsp_stall <= (tick % 5 < 2);
					endcase
				end
			end
		end
	end

	always @(posedge clk) begin : rsp_check
		rfd_pkg::rsp_t want;
		rfd_pkg::rsp_t got;
		string         diffs;
		if (arst_n && rsp_valid && !rsp_stall) begin
			got = rsp;
			if (due_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t unexpected result: %s", $time, rsp_str(got));
			end else begin
				want = due_results.pop_front();
				diffs = "";
				if (got.result_kind !== want.result_kind)     diffs = {diffs, " result_kind"};
				if (got.read_byte !== want.read_byte)         diffs = {diffs, " read_byte"};
				if (got.fifo_count !== want.fifo_count)       diffs = {diffs, " fifo_count"};
				if (got.frame_status !== want.frame_status)   diffs = {diffs, " frame_status"};
				if (got.channel_index !== want.channel_index) diffs = {diffs, " channel_index"};
				if (got.channel_value !== want.channel_value) diffs = {diffs, " channel_value"};
				if (got.discovered !== want.discovered)       diffs = {diffs, " discovered"};
				if (got.last !== want.last)                   diffs = {diffs, " last"};
				if (diffs != "") begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%0t result mismatch in%s", $time, diffs);
						$display("  exp %s", rsp_str(want));
						$display("  got %s", rsp_str(got));
					end
				end
			end
		end
	end

	// ends the run when no transfer of any kind happens for too long
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
					(psel && penable))
				idle = 0;
			else
				idle++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		req_valid = 1'b0;
		req       = '0;
		model_reset();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_fifo_full();
		test_config_sweep();
		test_backpressure();
		test_random_traffic();
		wait_drained();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== radio_rx_frame_dispatcher_core.f =====
sv/rfd_pkg.sv
sv/rfd_front.sv
sv/rfd_jobq.sv
sv/rfd_back.sv
sv/radio_rx_frame_dispatcher_core.sv
test/tb_top.sv
